@@ rtl/core/assert_macros.svh @@
// Assertion shorthands shared by the RTL. Every check samples on the rising
// clock edge and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/core/lz77td_pkg.sv @@
package lz77td_pkg;

   // History ring geometry.
   localparam int AddrWidth    = 12;
   localparam int HistoryDepth = 1 << AddrWidth;
   localparam int CountWidth   = AddrWidth + 1;

   // Token field widths.
   localparam int LenWidth  = 4;
   localparam int ByteWidth = 8;

   // One token as it arrives on the request channel.
   typedef struct packed {
      logic [AddrWidth-1:0] distance;
      logic [LenWidth-1:0]  copy_length;
      logic [ByteWidth-1:0] literal;
      logic                 final_token;
   } req_type;

   // One decompressed byte with its flags.
   typedef struct packed {
      logic [ByteWidth-1:0] out_byte;
      logic                 token_done;
      logic                 stream_done;
      logic                 bad_reference;
   } rsp_type;

endpackage

@@ rtl/core/lz77td_ring_ram.sv @@
module lz77td_ring_ram (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [lz77td_pkg::AddrWidth-1:0]   wr_addr,
   input  logic [lz77td_pkg::ByteWidth-1:0]   wr_data,
   input  logic                               rd_en,
   input  logic [lz77td_pkg::AddrWidth-1:0]   rd_addr,
   output logic [lz77td_pkg::ByteWidth-1:0]   rd_data
);
   import lz77td_pkg::*;

   logic [ByteWidth-1:0] mem [HistoryDepth];
   logic [ByteWidth-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lz77_token_decoder.sv @@
// LZ77 token decoder. Each request transfer carries one token (distance,
// copy_length, literal, final_token); the block answers with copy_length
// copied bytes followed by the literal, or with the literal alone when the
// distance is zero. Bytes come from a 4096-byte history ring held in one
// single-port-read, single-port-write RAM with registered read data. Every
// copied byte takes a ring read, then the write-back and output load, which
// lets a copy overlap bytes written by the same token. A token is accepted,
// its copied bytes follow and the literal comes last; output loads wait while
// the result channel stalls. req_ready is high only between tokens. A distance
// larger than the number of bytes produced so far flags bad_reference on every
// byte of the token and copies zeros. The ring needs no clearing after reset.
module lz77_token_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lz77td_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lz77td_pkg::rsp_type  rsp_data
);
   import lz77td_pkg::*;

   typedef enum logic [1:0] {
      IDLE,
      READ,
      DATA,
      LIT
   } state_type;

   state_type             state_ff, state_in;
   logic [AddrWidth-1:0]  wp_ff, wp_in;
   logic [CountWidth-1:0] produced_ff, produced_in;
   logic [AddrWidth-1:0]  dist_ff, dist_in;
   logic [LenWidth-1:0]   remain_ff, remain_in;
   logic [ByteWidth-1:0]  lit_ff, lit_in;
   logic                  fin_ff, fin_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  ring_we;
   logic [ByteWidth-1:0]  ring_wdata;
   logic                  ring_re;
   logic [AddrWidth-1:0]  ring_raddr;
   logic [ByteWidth-1:0]  ring_rdata;
   logic                  out_free;
   logic                  req_xfer;

   assign req_ready = (state_ff == IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // The copy source trails the write pointer by the token's distance.
   assign ring_raddr = wp_ff - dist_ff;
   assign ring_re    = (state_ff == READ);

   lz77td_ring_ram u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (ring_wdata),
      .rd_en   (ring_re),
      .rd_addr (ring_raddr),
      .rd_data (ring_rdata)
   );

   // Sequencer: next state, ring write and output register load.
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      produced_in  = produced_ff;
      dist_in      = dist_ff;
      remain_in    = remain_ff;
      lit_in       = lit_ff;
      fin_in       = fin_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ring_we      = 1'b0;
      ring_wdata   = lit_ff;

      case (state_ff)
         IDLE: begin
            if (req_xfer) begin
               dist_in = req_data.distance;
               lit_in  = req_data.literal;
               fin_in  = req_data.final_token;
               if (req_data.distance == '0) begin
                  remain_in = '0;
                  bad_in    = 1'b0;
                  state_in  = LIT;
               end else begin
                  remain_in = req_data.copy_length;
                  bad_in    = {1'b0, req_data.distance} > produced_ff;
                  state_in  = (req_data.copy_length == '0) ? LIT : READ;
               end
            end
         end
         READ: begin
            state_in = DATA;
         end
         DATA: begin
            if (out_free) begin
               ring_we                   = 1'b1;
               ring_wdata                = bad_ff ? '0 : ring_rdata;
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = ring_wdata;
               rsp_data_in.token_done    = 1'b0;
               rsp_data_in.stream_done   = 1'b0;
               rsp_data_in.bad_reference = bad_ff;
               remain_in                 = remain_ff - 1'b1;
               state_in                  = (remain_ff == LenWidth'(1)) ? LIT : READ;
            end
         end
         LIT: begin
            if (out_free) begin
               ring_we                   = 1'b1;
               ring_wdata                = lit_ff;
               rsp_valid_in              = 1'b1;
               rsp_data_in.out_byte      = lit_ff;
               rsp_data_in.token_done    = 1'b1;
               rsp_data_in.stream_done   = fin_ff;
               rsp_data_in.bad_reference = bad_ff;
               state_in                  = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase

      // Every ring write advances the pointer and the saturating byte count.
      if (ring_we) begin
         wp_in = wp_ff + 1'b1;
         if (produced_ff != CountWidth'(HistoryDepth)) begin
            produced_in = produced_ff + 1'b1;
         end
      end
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         wp_ff        <= '0;
         produced_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         produced_ff  <= produced_in;
         rsp_valid_ff <= rsp_valid_in;
         dist_ff      <= dist_in;
         remain_ff    <= remain_in;
         lit_ff       <= lit_in;
         fin_ff       <= fin_in;
         bad_ff       <= bad_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the sequencer and the history bookkeeping.
`include "assert_macros.svh"
   `ASSERT_SAME(a_count_sat, 1'b1, produced_ff <= CountWidth'(HistoryDepth))
   `ASSERT_SAME(a_stream_on_literal, rsp_valid && rsp_data.stream_done, rsp_data.token_done)
   `ASSERT_NEXT(a_wp_step, ring_we, wp_ff == $past(wp_ff) + 1'b1)
   `ASSERT_NEXT(a_accept_leaves_idle, req_xfer, state_ff != IDLE)

endmodule
